// ===== src/oeg_pkg.sv =====
`default_nettype none
// shared types, constants and the sine table builder for the orbit generator
package oeg_pkg;

  localparam int MUL_A_BITS     = 33;
  localparam int MUL_B_BITS     = 32;
  localparam int MUL_DIGIT_BITS = 4;
  localparam int MUL_DIGITS     = MUL_B_BITS / MUL_DIGIT_BITS;
  localparam int PROD_BITS      = MUL_A_BITS + MUL_B_BITS;
  localparam int SINE_MAG_BITS  = 31;
  localparam int TRIG_BITS      = 32;
  localparam int TERM_BITS      = 33;
  localparam int SUM_BITS       = 35;
  localparam int Q30_SHIFT      = 30;
  localparam int STEP_SCALE_BITS = 48;
  localparam int CFG_INDEX_BITS = 3;

  localparam logic [63:0] HALF_PI_Q40 = 64'd1727108826179;
  localparam logic [63:0] ONE_Q30 = 64'd1 << Q30_SHIFT;
  localparam logic signed [PROD_BITS-1:0] Q30_HALF =
    PROD_BITS'(64'd1 << (Q30_SHIFT - 1));

  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MAJOR_AXIS    = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MINOR_AXIS    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_ANGULAR_SPEED = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TILT_ANGLE    = 3'd5;

  typedef struct packed {
    logic [15:0] elapsed_time;
  } tick_req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
  } point_req_t;

  typedef struct packed {
    logic [CFG_INDEX_BITS-1:0] index;
    logic [31:0]               data;
  } cfg_req_t;

  typedef struct packed {
    logic                         start;
    logic signed [MUL_A_BITS-1:0] a;
    logic [MUL_B_BITS-1:0]        b;
  } mul_req_t;

  typedef struct packed {
    logic                        done;
    logic signed [PROD_BITS-1:0] product;
  } mul_rsp_t;

  function automatic logic [63:0] div_factor(logic [63:0] v, int unsigned n);
    logic [63:0] q;
    case (n)
      1: q = v / 6;
      2: q = v / 20;
      3: q = v / 42;
      4: q = v / 72;
      5: q = v / 110;
      6: q = v / 156;
      7: q = v / 210;
      default: q = v;
    endcase
    return q;
  endfunction

  // quarter-wave sine entry in Q1.30, evaluated at elaboration
  function automatic logic [SINE_MAG_BITS-1:0] sine_entry(int unsigned table_bits,
                                                          int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    x = (64'(k) * HALF_PI_Q40 + (64'd1 << (table_bits + 9))) >> (table_bits + 10);
    x2 = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum = $signed(x);
    for (int unsigned n = 1; n <= 7; n++) begin
      term = div_factor((term * x2 + (64'd1 << 29)) >> 30, n);
      if (n % 2 == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > $signed(ONE_Q30)) begin
      sum = $signed(ONE_Q30);
    end
    return sum[SINE_MAG_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/oeg_chan_if.sv =====
`default_nettype none
// valid/ready channel carrying one request of a given payload type
interface oeg_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/oeg_sine_rom.sv =====
`default_nettype none
// quarter-wave sine table with quadrant folding and registered read
module oeg_sine_rom #(
  parameter int TABLE_BITS = 8
) (
  input  logic                               clk,
  input  logic [TABLE_BITS+1:0]              angle,
  output logic [oeg_pkg::SINE_MAG_BITS-1:0]  mag,
  output logic                               neg
);
  import oeg_pkg::*;

  localparam int N = 1 << TABLE_BITS;
  localparam logic [TABLE_BITS:0] FULL = (TABLE_BITS + 1)'(N);

  logic [SINE_MAG_BITS-1:0] wave [N+1];
  logic [1:0]               quad;
  logic [TABLE_BITS-1:0]    step;
  logic [TABLE_BITS:0]      idx;

  for (genvar k = 0; k <= N; k++) begin : g_wave
    assign wave[k] = sine_entry(TABLE_BITS, k);
  end

  assign quad = angle[TABLE_BITS+1:TABLE_BITS];
  assign step = angle[TABLE_BITS-1:0];
  assign idx  = quad[0] ? (FULL - {1'b0, step}) : {1'b0, step};

  always_ff @(posedge clk) begin
    mag <= wave[idx];
    neg <= quad[1];
  end
endmodule
`default_nettype wire

// ===== src/oeg_serial_mult.sv =====
`default_nettype none
// digit-serial signed by unsigned multiplier, one digit of b per cycle
module oeg_serial_mult (
  input  logic               clk,
  input  logic               rst,
  input  oeg_pkg::mul_req_t  req,
  output oeg_pkg::mul_rsp_t  rsp
);
  import oeg_pkg::*;

  localparam int HI_BITS  = MUL_A_BITS + 1;
  localparam int ADD_BITS = MUL_A_BITS + MUL_DIGIT_BITS + 1;
  localparam int CNT_BITS = $clog2(MUL_DIGITS);
  localparam logic [CNT_BITS-1:0] LAST = CNT_BITS'(MUL_DIGITS - 1);

  logic                         busy;
  logic                         done;
  logic [CNT_BITS-1:0]          cnt;
  logic signed [MUL_A_BITS-1:0] a_reg;
  logic [MUL_B_BITS-1:0]        b_reg;
  logic signed [HI_BITS-1:0]    hi;
  logic [MUL_B_BITS-1:0]        lo;
  logic signed [ADD_BITS-1:0]   partial;
  logic signed [ADD_BITS-1:0]   acc;
  logic [HI_BITS+MUL_B_BITS-1:0] full;

  assign partial = ADD_BITS'(a_reg) *
                   ADD_BITS'($signed({1'b0, b_reg[MUL_DIGIT_BITS-1:0]}));
  assign acc     = ADD_BITS'(hi) + partial;
  assign full    = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a_reg <= req.a;
        b_reg <= req.b;
        hi    <= '0;
        lo    <= '0;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        hi    <= HI_BITS'(acc >>> MUL_DIGIT_BITS);
        lo    <= {acc[MUL_DIGIT_BITS-1:0], lo[MUL_B_BITS-1:MUL_DIGIT_BITS]};
        b_reg <= b_reg >> MUL_DIGIT_BITS;
        cnt   <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done    = done;
  assign rsp.product = $signed(full[PROD_BITS-1:0]);

  a_start_idle: assert property (@(posedge clk) disable iff (rst) req.start |-> !busy)
    else $error("multiplier started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("multiplier done without work");
  a_last_digit: assert property (@(posedge clk) disable iff (rst)
    (busy && !req.start && cnt == LAST) |=> done)
    else $error("multiplier missed its last digit");
endmodule
`default_nettype wire

// ===== src/rotated_ellipse_orbit_generator_top.sv =====
`default_nettype none
// rotated ellipse orbit generator: config registers, phase, sequencer, output register
//
// Each tick request yields one point request (pos_x, pos_y) at the orbit phase held
// before the tick; the phase then advances by (angular_speed * elapsed_time) >> 16.
// From acceptance until the block is ready again, a tick runs four sine table reads
// and nine products through one shared 4-bit digit-serial multiplier, then one sum
// step and one output step, which waits while an unread point is still held. The point
// waits in an output register, so a new tick is taken while it is still unread.
// Configuration writes are always accepted and must happen while the block is idle.
module rotated_ellipse_orbit_generator_top #(
  parameter int SINE_TABLE_BITS = 8,
  parameter int PHASE_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  oeg_chan_if.sink    tick,
  oeg_chan_if.source  point,
  oeg_chan_if.sink    cfg
);
  import oeg_pkg::*;

  localparam int CODE_BITS = SINE_TABLE_BITS + 2;
  localparam logic [CODE_BITS-1:0] QUARTER_CODE = {2'b01, {SINE_TABLE_BITS{1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK, S_MUL_GO, S_MUL_WAIT, S_SUM, S_EMIT
  } state_t;

  typedef enum logic [2:0] {
    LK_ST, LK_CT, LK_SG, LK_CG, LK_DONE
  } lk_t;

  typedef enum logic [3:0] {
    OP_CC, OP_SS, OP_CS, OP_SC, OP_XC, OP_XS, OP_YC, OP_YS, OP_STEP
  } op_t;

  state_t state;
  lk_t    lk;
  op_t    op;

  logic signed [31:0] center_x;
  logic signed [31:0] center_y;
  logic signed [31:0] major_axis;
  logic signed [31:0] minor_axis;
  logic signed [31:0] angular_speed;
  logic [15:0]        tilt_angle;

  logic [PHASE_BITS-1:0] orbit_phase;
  logic [15:0]           dt;

  logic [SINE_MAG_BITS-1:0] st_mag, ct_mag, sg_mag, cg_mag;
  logic                     st_neg, ct_neg, sg_neg, cg_neg;
  logic signed [TRIG_BITS-1:0] cc, ss, cs, sc;
  logic signed [TERM_BITS-1:0] t_xc, t_xs, t_yc, t_ys;
  logic signed [SUM_BITS-1:0]  x_sum, y_sum;

  logic               out_valid;
  logic signed [31:0] out_x, out_y;

  logic [CODE_BITS-1:0]     phase_code, tilt_code, rom_angle;
  logic [SINE_MAG_BITS-1:0] rom_mag;
  logic                     rom_neg;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  logic signed [PROD_BITS-1:0] prod_rnd;

  function automatic logic signed [MUL_A_BITS-1:0] trig_operand(
    logic [SINE_MAG_BITS-1:0] m, logic neg);
    logic signed [MUL_A_BITS-1:0] v;
    v = $signed(MUL_A_BITS'(m));
    return neg ? -v : v;
  endfunction

  function automatic logic signed [MUL_A_BITS-1:0] axis_operand(
    logic signed [31:0] axis, logic neg);
    logic signed [MUL_A_BITS-1:0] v;
    v = MUL_A_BITS'(axis);
    return neg ? -v : v;
  endfunction

  function automatic logic [MUL_B_BITS-1:0] magnitude(logic signed [TRIG_BITS-1:0] t);
    logic signed [TRIG_BITS-1:0] v;
    v = t[TRIG_BITS-1] ? -t : t;
    return MUL_B_BITS'(v);
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [SUM_BITS-1:0] s);
    logic signed [31:0] r;
    if (s[SUM_BITS-1:31] == '0 || s[SUM_BITS-1:31] == '1) begin
      r = s[31:0];
    end else if (s[SUM_BITS-1]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // config registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      major_axis    <= '0;
      minor_axis    <= '0;
      angular_speed <= '0;
      tilt_angle    <= '0;
    end else if (cfg.valid) begin
      case (cfg.payload.index)
        REG_CENTER_X:      center_x      <= cfg.payload.data;
        REG_CENTER_Y:      center_y      <= cfg.payload.data;
        REG_MAJOR_AXIS:    major_axis    <= cfg.payload.data;
        REG_MINOR_AXIS:    minor_axis    <= cfg.payload.data;
        REG_ANGULAR_SPEED: angular_speed <= cfg.payload.data;
        REG_TILT_ANGLE:    tilt_angle    <= cfg.payload.data[15:0];
        default: ;
      endcase
    end
  end

  // sine table lookups
  assign phase_code = orbit_phase[PHASE_BITS-1 -: CODE_BITS];
  assign tilt_code  = tilt_angle[15 -: CODE_BITS];

  always_comb begin
    case (lk)
      LK_ST:   rom_angle = phase_code;
      LK_CT:   rom_angle = phase_code + QUARTER_CODE;
      LK_SG:   rom_angle = tilt_code;
      LK_CG:   rom_angle = tilt_code + QUARTER_CODE;
      default: rom_angle = phase_code;
    endcase
  end

  oeg_sine_rom #(
    .TABLE_BITS (SINE_TABLE_BITS)
  ) u_rom (
    .clk   (clk),
    .angle (rom_angle),
    .mag   (rom_mag),
    .neg   (rom_neg)
  );

  // multiplier operands
  always_comb begin
    mul_req.start = (state == S_MUL_GO);
    case (op)
      OP_CC: begin
        mul_req.a = trig_operand(ct_mag, ct_neg ^ cg_neg);
        mul_req.b = MUL_B_BITS'(cg_mag);
      end
      OP_SS: begin
        mul_req.a = trig_operand(st_mag, st_neg ^ sg_neg);
        mul_req.b = MUL_B_BITS'(sg_mag);
      end
      OP_CS: begin
        mul_req.a = trig_operand(ct_mag, ct_neg ^ sg_neg);
        mul_req.b = MUL_B_BITS'(sg_mag);
      end
      OP_SC: begin
        mul_req.a = trig_operand(st_mag, st_neg ^ cg_neg);
        mul_req.b = MUL_B_BITS'(cg_mag);
      end
      OP_XC: begin
        mul_req.a = axis_operand(major_axis, cc[TRIG_BITS-1]);
        mul_req.b = magnitude(cc);
      end
      OP_XS: begin
        mul_req.a = axis_operand(minor_axis, ss[TRIG_BITS-1]);
        mul_req.b = magnitude(ss);
      end
      OP_YC: begin
        mul_req.a = axis_operand(major_axis, cs[TRIG_BITS-1]);
        mul_req.b = magnitude(cs);
      end
      OP_YS: begin
        mul_req.a = axis_operand(minor_axis, sc[TRIG_BITS-1]);
        mul_req.b = magnitude(sc);
      end
      default: begin
        mul_req.a = MUL_A_BITS'(angular_speed);
        mul_req.b = MUL_B_BITS'(dt);
      end
    endcase
  end

  oeg_serial_mult u_mult (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  assign prod_rnd = mul_rsp.product + Q30_HALF;

  // sequencer
  assign tick.ready    = (state == S_IDLE);
  assign point.valid   = out_valid;
  assign point.payload = '{pos_x: out_x, pos_y: out_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lk          <= LK_ST;
      op          <= OP_CC;
      out_valid   <= 1'b0;
      orbit_phase <= '0;
    end else begin
      if (point.valid && point.ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (tick.valid) begin
            dt    <= tick.payload.elapsed_time;
            lk    <= LK_ST;
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          lk <= lk_t'(lk + 3'd1);
          case (lk)
            LK_CT: begin
              st_mag <= rom_mag;
              st_neg <= rom_neg;
            end
            LK_SG: begin
              ct_mag <= rom_mag;
              ct_neg <= rom_neg;
            end
            LK_CG: begin
              sg_mag <= rom_mag;
              sg_neg <= rom_neg;
            end
            LK_DONE: begin
              cg_mag <= rom_mag;
              cg_neg <= rom_neg;
              op     <= OP_CC;
              state  <= S_MUL_GO;
            end
            default: ;
          endcase
        end
        S_MUL_GO: begin
          state <= S_MUL_WAIT;
        end
        S_MUL_WAIT: begin
          if (mul_rsp.done) begin
            case (op)
              OP_CC: cc   <= prod_rnd[Q30_SHIFT +: TRIG_BITS];
              OP_SS: ss   <= prod_rnd[Q30_SHIFT +: TRIG_BITS];
              OP_CS: cs   <= prod_rnd[Q30_SHIFT +: TRIG_BITS];
              OP_SC: sc   <= prod_rnd[Q30_SHIFT +: TRIG_BITS];
              OP_XC: t_xc <= prod_rnd[Q30_SHIFT +: TERM_BITS];
              OP_XS: t_xs <= prod_rnd[Q30_SHIFT +: TERM_BITS];
              OP_YC: t_yc <= prod_rnd[Q30_SHIFT +: TERM_BITS];
              OP_YS: t_ys <= prod_rnd[Q30_SHIFT +: TERM_BITS];
              default: begin
                orbit_phase <= orbit_phase +
                               mul_rsp.product[STEP_SCALE_BITS-1 -: PHASE_BITS];
              end
            endcase
            if (op == OP_STEP) begin
              state <= S_SUM;
            end else begin
              op    <= op_t'(op + 4'd1);
              state <= S_MUL_GO;
            end
          end
        end
        S_SUM: begin
          x_sum <= SUM_BITS'(center_x) + SUM_BITS'(t_xc) - SUM_BITS'(t_xs);
          y_sum <= SUM_BITS'(center_y) + SUM_BITS'(t_yc) + SUM_BITS'(t_ys);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || point.ready) begin
            out_x     <= sat32(x_sum);
            out_y     <= sat32(y_sum);
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_tick_starts_lookup: assert property (@(posedge clk) disable iff (rst)
    (tick.valid && tick.ready) |=> (state == S_LOOK))
    else $error("accepted tick did not start a lookup");
  a_point_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(point.valid) |-> $past(state == S_EMIT))
    else $error("point raised outside the output step");
  a_phase_moves_on_step: assert property (@(posedge clk) disable iff (rst)
    !$stable(orbit_phase) |-> $past(state == S_MUL_WAIT && op == OP_STEP && mul_rsp.done))
    else $error("phase changed outside the phase step");
  a_start_in_go: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_GO) |=> (state == S_MUL_WAIT && !mul_rsp.done))
    else $error("multiplier result seen too early");
endmodule
`default_nettype wire
